// ===== hdl/sdx_pkg.sv =====
// shared widths, mode codes and saturation for the spectral divide-by-x core
package sdx_pkg;

    localparam int VAL_W  = 48;
    localparam int ACC_W  = 56;
    localparam int W_W    = 31;
    localparam int FRAC_W = 30;
    localparam int DEN_W  = 7;
    localparam int NUM_W  = 38;
    localparam int AL_W   = 24;
    localparam int AH_W   = VAL_W - AL_W;
    localparam int PART_W = AL_W + W_W;
    localparam int FULL_W = VAL_W + W_W;

    localparam logic [1:0] MODE_CHEB_EVEN = 2'd0;
    localparam logic [1:0] MODE_CHEB_ODD  = 2'd1;
    localparam logic [1:0] MODE_LEG_EVEN  = 2'd2;
    localparam logic [1:0] MODE_LEG_ODD   = 2'd3;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        lo_lim = ~hi_lim;
        if (v > hi_lim) begin
            return hi_lim[VAL_W-1:0];
        end else if (v < lo_lim) begin
            return lo_lim[VAL_W-1:0];
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/sdx_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module sdx_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sdx_pkg::NUM_W-1:0] num,
    input  logic [sdx_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [sdx_pkg::NUM_W-1:0] quot
);
    import sdx_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                q_reg    <= num;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                end else begin
                    rem_reg <= trial[DEN_W-1:0];
                end
                q_reg   <= {q_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg)) else $error("done without iteration");
    a_cnt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !start |=> !busy_reg) else $error("divider started by itself");

endmodule

// ===== hdl/sdx_wmul.sv =====
// weight times coefficient with rounding to q31.24, three stages
module sdx_wmul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    input  logic signed [sdx_pkg::VAL_W-1:0] a,
    input  logic [sdx_pkg::W_W-1:0]          w,
    input  logic                             neg,
    output logic                             out_valid,
    output logic signed [sdx_pkg::ACC_W-1:0] prod
);
    import sdx_pkg::*;

    logic [VAL_W-1:0]        ua_reg;
    logic [W_W-1:0]          w_reg;
    logic                    sgn1_reg;
    logic [PART_W-1:0]       hi_reg;
    logic [PART_W-1:0]       lo_reg;
    logic                    sgn2_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic [2:0]              vld_reg;
    logic [FULL_W-1:0]       full;
    logic [FULL_W-1:0]       rnd;
    logic [ACC_W-1:0]        mag;

    assign full = {hi_reg, {AL_W{1'b0}}} + FULL_W'(lo_reg);
    assign rnd  = full + (FULL_W'(1) << (FRAC_W - 1));
    assign mag  = ACC_W'(rnd[FULL_W-1:FRAC_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
        ua_reg   <= a[VAL_W-1] ? VAL_W'(-a) : a;
        w_reg    <= w;
        sgn1_reg <= neg ^ a[VAL_W-1];
        hi_reg   <= PART_W'(ua_reg[VAL_W-1:AL_W]) * PART_W'(w_reg);
        lo_reg   <= PART_W'(ua_reg[AL_W-1:0]) * PART_W'(w_reg);
        sgn2_reg <= sgn1_reg;
        prod_reg <= sgn2_reg ? -$signed(mag) : $signed(mag);
    end

    assign out_valid = vld_reg[2];
    assign prod      = prod_reg;

endmodule

// ===== hdl/spectral_divide_by_x_core.sv =====
// spectral divide-by-x core: coefficient store, result store and sequencer
// load stores each accepted item; after the final item the set is worked out, chebyshev
// modes with a read state and an accumulate state per coefficient, legendre modes with a
// divide for the weight and the 3-stage multiplier per weight term, n*(n+1)/2 terms (odd)
// or n*(n-1)/2 (even); results leave one at a time, read once the output register is empty
// one set at a time; reset clears control state, the coefficient memory is not cleared
module spectral_divide_by_x_core #(
    parameter int MAX_COEFFS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // coefficient
    input  logic [1:0]  s_tuser,   // mode
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_value
    output logic [1:0]  m_tuser,   // result_basis
    output logic        m_tlast    // last_out
);
    import sdx_pkg::*;

    localparam int AW = $clog2(MAX_COEFFS);

    typedef enum logic [3:0] {
        ST_LOAD, ST_ZERO, ST_CH_RD, ST_CH_ACC, ST_LG_I, ST_LG_GO,
        ST_LG_DIV, ST_LG_MUL, ST_EM_RD, ST_EM_LD
    } state_t;

    state_t state_reg;

    logic signed [VAL_W-1:0] coef_mem [MAX_COEFFS];
    logic signed [VAL_W-1:0] res_mem  [MAX_COEFFS];
    logic signed [VAL_W-1:0] coef_q;
    logic signed [VAL_W-1:0] res_q;

    logic [AW-1:0]           cnt_reg;
    logic [AW-1:0]           last_reg;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           j_reg;
    logic [1:0]              mode_reg;
    logic                    sg_reg;
    logic                    neg_reg;
    logic                    first_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic [W_W-1:0]          w_reg;
    logic [NUM_W-1:0]        dnum_reg;
    logic [DEN_W-1:0]        dden_reg;
    logic                    div_start_reg;
    logic                    mul_start_reg;
    logic                    m_tvalid_reg;
    logic [47:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;
    logic                    m_tlast_reg;

    logic                    s_acc;
    logic                    coef_re;
    logic [AW-1:0]           coef_raddr;
    logic                    res_we;
    logic [AW-1:0]           res_waddr;
    logic signed [VAL_W-1:0] res_wdata;
    logic                    res_re;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quot;
    logic                    mul_done;
    logic signed [ACC_W-1:0] mul_prod;

    logic signed [ACC_W-1:0] ch_term;
    logic signed [ACC_W-1:0] ch_sum;
    logic signed [ACC_W-1:0] ch_neg;
    logic signed [ACC_W-1:0] ch_val;
    logic signed [ACC_W-1:0] lg_sum;
    logic [AW-1:0]           lg_last;
    logic [DEN_W-1:0]        j2;
    logic [DEN_W-1:0]        lg_mult;
    logic [DEN_W-1:0]        lg_den;
    logic [NUM_W-1:0]        num_first;
    logic [NUM_W-1:0]        num_next;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;

    assign ch_term = ACC_W'(coef_q) <<< 1;
    assign ch_sum  = sg_reg ? sum_reg - ch_term : sum_reg + ch_term;
    assign ch_neg  = pos_reg[0] ? ch_sum : -ch_sum;
    assign ch_val  = (mode_reg == MODE_CHEB_ODD && pos_reg == '0) ? (ch_neg >>> 1) : ch_neg;
    assign lg_sum  = sum_reg + mul_prod;
    assign lg_last = (mode_reg == MODE_LEG_ODD) ? last_reg : last_reg - 1'b1;

    assign j2        = DEN_W'({j_reg, 1'b0});
    assign lg_mult   = (mode_reg == MODE_LEG_ODD) ? j2 : j2 - 1'b1;
    assign lg_den    = (mode_reg == MODE_LEG_ODD) ? j2 + 1'b1 : j2;
    assign num_first = ((NUM_W'(lg_mult) + NUM_W'(lg_den)) << FRAC_W) + NUM_W'(j_reg);
    assign num_next  = NUM_W'(NUM_W'(w_reg) * NUM_W'(lg_mult)) + NUM_W'(j_reg);

    always_comb begin
        coef_re    = 1'b0;
        coef_raddr = j_reg;
        res_we     = 1'b0;
        res_waddr  = pos_reg;
        res_wdata  = '0;
        res_re     = 1'b0;
        case (state_reg)
            ST_ZERO: begin
                res_we    = (mode_reg != MODE_LEG_ODD);
                res_waddr = last_reg;
            end
            ST_CH_RD: begin
                coef_re    = 1'b1;
                coef_raddr = (mode_reg == MODE_CHEB_EVEN) ? pos_reg + 1'b1 : pos_reg;
            end
            ST_CH_ACC: begin
                res_we    = 1'b1;
                res_wdata = sat_val(ch_val);
            end
            ST_LG_GO: begin
                coef_re = 1'b1;
            end
            ST_LG_MUL: begin
                res_we    = mul_done && (j_reg == last_reg);
                res_wdata = sat_val(lg_sum);
            end
            ST_EM_RD: begin
                res_re = !m_tvalid_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            coef_mem[cnt_reg] <= s_tdata;
        end
        if (coef_re) begin
            coef_q <= coef_mem[coef_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[res_waddr] <= res_wdata;
        end
        if (res_re) begin
            res_q <= res_mem[cnt_reg];
        end
    end

    sdx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (dnum_reg),
        .den     (dden_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    sdx_wmul u_wmul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_start_reg),
        .a         (coef_q),
        .w         (w_reg),
        .neg       (neg_reg),
        .out_valid (mul_done),
        .prod      (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            mode_reg      <= MODE_CHEB_EVEN;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (cnt_reg == '0) begin
                            mode_reg <= s_tuser;
                        end
                        if (s_tlast || cnt_reg == AW'(MAX_COEFFS - 1)) begin
                            last_reg  <= cnt_reg;
                            state_reg <= ST_ZERO;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_ZERO: begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    sg_reg  <= 1'b0;
                    if (mode_reg == MODE_LEG_ODD) begin
                        pos_reg   <= '0;
                        state_reg <= ST_LG_I;
                    end else if (last_reg == '0) begin
                        state_reg <= ST_EM_RD;
                    end else if (mode_reg == MODE_LEG_EVEN) begin
                        pos_reg   <= '0;
                        state_reg <= ST_LG_I;
                    end else begin
                        pos_reg   <= last_reg - 1'b1;
                        state_reg <= ST_CH_RD;
                    end
                end
                ST_CH_RD: begin
                    state_reg <= ST_CH_ACC;
                end
                ST_CH_ACC: begin
                    sum_reg <= ch_sum;
                    sg_reg  <= ~sg_reg;
                    if (pos_reg == '0) begin
                        state_reg <= ST_EM_RD;
                    end else begin
                        pos_reg   <= pos_reg - 1'b1;
                        state_reg <= ST_CH_RD;
                    end
                end
                ST_LG_I: begin
                    j_reg     <= (mode_reg == MODE_LEG_ODD) ? pos_reg : pos_reg + 1'b1;
                    first_reg <= 1'b1;
                    neg_reg   <= 1'b0;
                    sum_reg   <= '0;
                    state_reg <= ST_LG_GO;
                end
                ST_LG_GO: begin
                    dnum_reg      <= first_reg ? num_first : num_next;
                    dden_reg      <= lg_den;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_LG_DIV;
                end
                ST_LG_DIV: begin
                    if (div_done) begin
                        w_reg         <= div_quot[W_W-1:0];
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_LG_MUL;
                    end
                end
                ST_LG_MUL: begin
                    if (mul_done) begin
                        sum_reg <= lg_sum;
                        if (j_reg == last_reg) begin
                            if (pos_reg == lg_last) begin
                                state_reg <= ST_EM_RD;
                            end else begin
                                pos_reg   <= pos_reg + 1'b1;
                                state_reg <= ST_LG_I;
                            end
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            neg_reg   <= ~neg_reg;
                            first_reg <= 1'b0;
                            state_reg <= ST_LG_GO;
                        end
                    end
                end
                ST_EM_RD: begin
                    if (!m_tvalid_reg) begin
                        state_reg <= ST_EM_LD;
                    end
                end
                ST_EM_LD: begin
                    m_tdata_reg  <= res_q;
                    m_tuser_reg  <= mode_reg ^ 2'b01;
                    m_tlast_reg  <= (cnt_reg == last_reg);
                    m_tvalid_reg <= 1'b1;
                    if (cnt_reg == last_reg) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_EM_RD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> cnt_reg <= AW'(MAX_COEFFS - 1))
        else $error("load index past store depth");
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> state_reg == ST_LG_DIV)
        else $error("divider started outside weight step");
    a_mul_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_LG_MUL)
        else $error("product arrived outside accumulate step");
    a_no_load_read: assert property (@(posedge aclk) disable iff (!aresetn)
        coef_re |-> !s_tready)
        else $error("coefficient read during load");

endmodule

// ===== bench/spectral_divide_by_x_core_tb.sv =====
// testbench for the spectral divide-by-x core: directed and random sets checked by a predictor
`timescale 1ns / 1ps

module spectral_divide_by_x_core_tb;
    import sdx_pkg::*;

    localparam int NCOEF      = 32;
    localparam int CYCLE_CAP  = 3000000;
    localparam int TARGET     = 110;
    localparam logic [47:0] VMAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] VMIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] coef;
        logic        last;
    } coef_item_t;

    typedef struct packed {
        logic [47:0] value;
        logic [1:0]  basis;
        logic        last;
    } div_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    coef_item_t  pending_items[$];
    div_result_t expected_results[$];
    longint      coef_mem[NCOEF];
    longint      quotient[NCOEF];
    int          load_idx = 0;
    logic [1:0]  set_mode = MODE_CHEB_EVEN;
    int          failures = 0;
    int          cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          in_took = 1'b0;
    bit          quiet = 1'b0;
    bit          stim_done = 1'b0;

    spectral_divide_by_x_core #(.MAX_COEFFS(NCOEF)) uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [1:0] result_basis_of(logic [1:0] m);
        case (m)
            MODE_CHEB_EVEN: return MODE_CHEB_ODD;
            MODE_CHEB_ODD:  return MODE_CHEB_EVEN;
            MODE_LEG_EVEN:  return MODE_LEG_ODD;
            default:        return MODE_LEG_EVEN;
        endcase
    endfunction

    function automatic longint clamp48(longint v);
        if (v > 64'sd140737488355327) return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    // weight magnitude in q1.30 times a q23.24 value, ties away from zero
    function automatic longint weight_mul(longint unsigned wm, bit wneg, longint a);
        bit aneg;
        longint unsigned ua, hi, lo, m;
        aneg = a < 0;
        ua = aneg ? longint'(-a) : longint'(a);
        hi = (ua >> 24) * wm;
        lo = (ua & 64'hFF_FFFF) * wm;
        m = (hi >> 6) + ((((hi & 64'd63) << 24) + lo + (64'd1 << 29)) >> 30);
        return (wneg ^ aneg) ? -longint'(m) : longint'(m);
    endfunction

    function automatic void divide_set(int nr);
        longint s, sg;
        longint unsigned w, d;
        bit neg;
        for (int i = 0; i < nr; i++) quotient[i] = 0;
        if (set_mode == MODE_CHEB_EVEN || set_mode == MODE_CHEB_ODD) begin
            if (nr < 2) return;
            sg = 1;
            s = 2 * (set_mode == MODE_CHEB_EVEN ? coef_mem[nr-1] : coef_mem[nr-2]);
            quotient[nr-2] = s;
            for (int i = nr - 3; i >= 0; i--) begin
                sg = -sg;
                s += sg * 2 * (set_mode == MODE_CHEB_EVEN ? coef_mem[i+1] : coef_mem[i]);
                quotient[i] = s;
            end
            for (int i = 0; i < nr; i += 2) quotient[i] = -quotient[i];
            if (set_mode == MODE_CHEB_ODD) begin
                quotient[0] = quotient[0] >= 0 ? quotient[0] / 2 : -((-quotient[0] + 1) / 2);
            end
        end else if (set_mode == MODE_LEG_ODD) begin
            for (int i = 0; i < nr; i++) begin
                d = 2 * i + 1;
                w = ((longint'(4 * i + 1) << 30) + d / 2) / d;
                neg = 1'b0;
                s = weight_mul(w, neg, coef_mem[i]);
                for (int j = i + 1; j < nr; j++) begin
                    d = 2 * j + 1;
                    w = (w * (2 * j) + d / 2) / d;
                    neg = ~neg;
                    s += weight_mul(w, neg, coef_mem[j]);
                end
                quotient[i] = s;
            end
        end else begin
            for (int i = 0; i < nr - 1; i++) begin
                d = 2 * i + 2;
                w = ((longint'(4 * i + 3) << 30) + d / 2) / d;
                neg = 1'b0;
                s = weight_mul(w, neg, coef_mem[i+1]);
                for (int j = i + 2; j < nr; j++) begin
                    d = 2 * j;
                    w = (w * (2 * j - 1) + d / 2) / d;
                    neg = ~neg;
                    s += weight_mul(w, neg, coef_mem[j]);
                end
                quotient[i] = s;
            end
        end
    endfunction

    function automatic void load_coef(coef_item_t it);
        div_result_t r;
        int idx;
        idx = load_idx;
        if (idx == 0) set_mode = it.mode;
        coef_mem[idx] = longint'($signed(it.coef));
        if (!it.last && idx + 1 < NCOEF) begin
            load_idx = idx + 1;
            return;
        end
        load_idx = 0;
        divide_set(idx + 1);
        for (int k = 0; k <= idx; k++) begin
            r.value = 48'(clamp48(quotient[k]));
            r.basis = result_basis_of(set_mode);
            r.last  = (k == idx);
            expected_results.push_back(r);
        end
    endfunction

    function automatic logic [47:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return VMAX;
            1: return VMIN;
            2: return 48'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic void push_set(logic [1:0] m, int n, bit close_by_last);
        coef_item_t it;
        for (int k = 0; k < n; k++) begin
            it.mode = (k == 0) ? m : 2'($urandom);
            it.coef = rand_coef();
            it.last = (k == n - 1) && close_by_last;
            pending_items.push_back(it);
        end
    endfunction

    // accept side: predictor and result check
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        in_took <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            load_coef('{s_tuser, s_tdata, s_tlast});
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result value=%h basis=%0d last=%0b",
                         $time, m_tdata, m_tuser, m_tlast);
                failures++;
            end else begin
                div_result_t e;
                e = expected_results.pop_front();
                if (m_tdata !== e.value) begin
                    $display("%0t: value expected %h actual %h", $time, e.value, m_tdata);
                    failures++;
                end
                if (m_tuser !== e.basis) begin
                    $display("%0t: basis expected %0d actual %0d", $time, e.basis, m_tuser);
                    failures++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, e.last, m_tlast);
                    failures++;
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // item driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_took)) begin
            if (in_gap > 0 && !quiet) begin
                in_gap <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                in_gap <= $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                coef_item_t it;
                it = pending_items.pop_front();
                s_tdata  <= it.coef;
                s_tuser  <= it.mode;
                s_tlast  <= it.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result stall
    always @(negedge aclk) begin
        if (!aresetn || quiet) begin
            m_tready <= aresetn;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_gap <= $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int total;
        // single coefficient in each chebyshev mode
        pending_items.push_back('{MODE_CHEB_EVEN, VMAX, 1'b1});
        pending_items.push_back('{MODE_CHEB_ODD, VMIN, 1'b1});
        // legendre sets at the extremes, even mode with two items
        pending_items.push_back('{MODE_LEG_EVEN, VMAX, 1'b0});
        pending_items.push_back('{MODE_LEG_ODD, VMIN, 1'b1});
        pending_items.push_back('{MODE_LEG_ODD, VMAX, 1'b0});
        pending_items.push_back('{MODE_CHEB_EVEN, VMIN, 1'b0});
        pending_items.push_back('{MODE_CHEB_ODD, VMAX, 1'b1});
        // chebyshev saturation, both directions, then legendre even and odd sets
        for (int k = 0; k < 4; k++) pending_items.push_back('{MODE_CHEB_EVEN, VMAX, k == 3});
        for (int k = 0; k < 4; k++)
            pending_items.push_back('{MODE_CHEB_ODD, k[0] ? VMAX : VMIN, k == 3});
        for (int k = 0; k < 4; k++) pending_items.push_back('{MODE_LEG_EVEN, VMIN, k == 3});
        pending_items.push_back('{MODE_LEG_ODD, 48'd1, 1'b0});
        pending_items.push_back('{MODE_LEG_ODD, 48'hFFFF_FFFF_FFFF, 1'b1});
        total = pending_items.size();
        // random sets: mostly short, now and then a full store closed either way
        while (total < TARGET) begin
            int n;
            bit full;
            full = ($urandom_range(0, 9) == 0);
            n = full ? NCOEF : $urandom_range(1, 8);
            push_set(2'($urandom), n, full ? 1'($urandom_range(0, 1)) : 1'b1);
            total += n;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() < 20);
        quiet = 1'b1;
        wait (pending_items.size() == 0);
        @(posedge aclk);
        while (s_tvalid || expected_results.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
